// ===== rtl/core/hybrid_quick_insertion_sort_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hybrid quick/insertion sort unit
// Each macro compiles to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HYBRID_QUICK_INSERTION_SORT_UNIT_DEFINES_SVH
`define HYBRID_QUICK_INSERTION_SORT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HQIS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hqis check failed");
`define HQIS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hqis check failed");
`else
`define HQIS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define HQIS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/hqis_pkg.sv =====
// ----------------------------------------------------------------------------
// hqis_pkg
// Types and constants shared by the sort unit modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hqis_pkg;
  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned SmallSeg    = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               truncated;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_POP, ST_POPW, ST_SEG,
    ST_INS_A, ST_INS_RD, ST_INS_CMP, ST_INS_WR,
    ST_PIV_RD, ST_PIV_CMP,
    ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_CMP, ST_SWAP, ST_PUSH,
    ST_OUT_RD, ST_OUT_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic lt;   // a < b signed
    logic eq;
  } cmp_t;
endpackage
`default_nettype wire

// ===== rtl/core/hqis_cmp.sv =====
// ----------------------------------------------------------------------------
// hqis_cmp
// Shared signed comparator used by every compare step of the sort.
// ----------------------------------------------------------------------------
`default_nettype none
module hqis_cmp import hqis_pkg::*; (
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output      cmp_t               res_o
);
  assign res_o.lt = a_i < b_i;
  assign res_o.eq = a_i == b_i;
endmodule
`default_nettype wire

// ===== rtl/core/hybrid_quick_insertion_sort_unit.sv =====
// ----------------------------------------------------------------------------
// hybrid_quick_insertion_sort_unit
// Loads signed words, sorts them on the last one, streams them out ascending.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle. From the last word until the final output
// word is issued the input is not ready: the unit sorts with quicksort over an
// explicit bounds stack, insertion sort below ten elements, one item store
// with one read and one write port and one shared comparator. The pivot scan
// reads neighbour pairs until two differ, a partition scan compares elements
// with the pivot and swaps out-of-place pairs, an insertion shift reads,
// compares and writes back; output then reads, waits and issues each word
// while the receiver keeps up.
`default_nettype none
`include "hybrid_quick_insertion_sort_unit_defines.svh"
module hybrid_quick_insertion_sort_unit import hqis_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_word_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_word_t out_data_o
);
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = 2 * AW;
  localparam logic [CW-1:0] CapC = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] SmallC = CW'(SmallSeg);

  logic signed [31:0] mem_q [MAX_ITEMS];
  logic [SW-1:0]      stk_q [MAX_ITEMS];
  logic signed [31:0] rd_q;
  logic [SW-1:0]      srd_q;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, sp_q, sp_d;
  logic          ovf_q, ovf_d;
  logic [CW:0]   lo_q, lo_d, hi_q, hi_d, up_q, up_d, dn_q, dn_d, a_q, a_d, b_q, b_d;
  logic signed [31:0] x_q, x_d, piv_q, piv_d;
  logic          ph_q, ph_d;   // second read of a pair / second push
  logic          out_v_q, out_v_d;
  out_word_t     out_q, out_d;

  logic          we, swe;
  logic [AW-1:0] wa, ra, swa, sra;
  logic signed [31:0] wd;
  logic [SW-1:0] swd;
  logic signed [31:0] ca, cb;
  cmp_t          cr;

  hqis_cmp u_cmp (.a_i(ca), .b_i(cb), .res_o(cr));

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
    if (swe) stk_q[swa] <= swd;
    srd_q <= stk_q[sra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; cnt_q <= '0; sp_q <= '0; ovf_q <= 1'b0;
      out_v_q <= 1'b0; ph_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; sp_q <= sp_d; ovf_q <= ovf_d;
      out_v_q <= out_v_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; up_q <= up_d; dn_q <= dn_d; a_q <= a_d; b_q <= b_d;
    x_q <= x_d; piv_q <= piv_d; out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; sp_d = sp_q; ovf_d = ovf_q; ph_d = ph_q;
    lo_d = lo_q; hi_d = hi_q; up_d = up_q; dn_d = dn_q; a_d = a_q; b_d = b_q;
    x_d = x_q; piv_d = piv_q; out_v_d = out_v_q; out_d = out_q;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    swe = 1'b0; swa = '0; swd = '0; sra = '0;
    ca = rd_q; cb = x_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CapC) begin
            we = 1'b1; wa = cnt_q[AW-1:0]; wd = in_data_i.value; cnt_d = cnt_q + 1'b1;
          end else ovf_d = 1'b1;
          if (in_data_i.last) begin
            swe = 1'b1; swa = '0;
            swd = {AW'(0), AW'((cnt_q < CapC ? cnt_q : cnt_q - 1'b1))};
            sp_d = CW'(1);
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          a_d = '0; state_d = ST_OUT_RD;
        end else begin
          sp_d = sp_q - 1'b1; sra = sp_d[AW-1:0]; state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_d = (CW+1)'(srd_q[SW-1:AW]); hi_d = (CW+1)'(srd_q[AW-1:0]);
        state_d = ST_SEG;
      end
      ST_SEG: begin
        if (hi_q - lo_q + 1'b1 < (CW+1)'(SmallC)) begin
          a_d = lo_q + 1'b1; state_d = ST_INS_A;
        end else begin
          a_d = lo_q; ph_d = 1'b0; ra = lo_q[AW-1:0]; state_d = ST_PIV_RD;
        end
      end
      // insertion sort: x holds a[b+1], rd is a[b]
      ST_INS_A: begin
        if (a_q > hi_q) state_d = ST_POP;
        else begin
          b_d = a_q - 1'b1; ra = a_q[AW-1:0]; ph_d = 1'b0; state_d = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        if (!ph_q) begin
          x_d = rd_q; ra = b_q[AW-1:0]; ph_d = 1'b1;
        end else state_d = ST_INS_CMP;
        if (ph_q) ra = b_q[AW-1:0];
      end
      ST_INS_CMP: begin
        ca = x_q; cb = rd_q;
        if (cr.lt) begin
          we = 1'b1; wa = AW'(b_q + 1'b1); wd = rd_q; state_d = ST_INS_WR;
        end else begin
          a_d = a_q + 1'b1; state_d = ST_INS_A;
        end
      end
      ST_INS_WR: begin
        we = 1'b1; wa = b_q[AW-1:0]; wd = x_q;
        if (b_q == lo_q) begin
          a_d = a_q + 1'b1; state_d = ST_INS_A;
        end else begin
          b_d = b_q - 1'b1; ra = AW'(b_q - 1'b1); ph_d = 1'b1; state_d = ST_INS_RD;
        end
      end
      // pivot search: a_q indexes pair (k, k+1)
      ST_PIV_RD: begin
        ra = AW'(a_q + 1'b1); x_d = rd_q; state_d = ST_PIV_CMP;
      end
      ST_PIV_CMP: begin
        ca = x_q; cb = rd_q;
        if (!cr.eq) begin
          piv_d = cr.lt ? rd_q : x_q; up_d = lo_q; dn_d = hi_q; state_d = ST_UP_RD;
        end else if (a_q + 1'b1 >= hi_q) state_d = ST_POP;
        else begin
          a_d = a_q + 1'b1; x_d = rd_q; ra = AW'(a_q + 2'd2);
        end
      end
      ST_UP_RD: begin
        if (up_q > dn_q) state_d = ST_PUSH;
        else if (up_q > hi_q) state_d = ST_DN_RD;
        else begin ra = up_q[AW-1:0]; state_d = ST_UP_CMP; end
        ph_d = 1'b0;
      end
      ST_UP_CMP: begin
        ca = rd_q; cb = piv_q;
        if (cr.lt) begin
          up_d = up_q + 1'b1;
          if (up_q + 1'b1 > hi_q) state_d = ST_DN_RD;
          else ra = AW'(up_q + 1'b1);
        end else begin
          x_d = rd_q; state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (dn_q[CW] || dn_q < lo_q) begin
          state_d = (up_q <= dn_q) ? ST_SWAP : ST_PUSH;
        end else begin ra = dn_q[AW-1:0]; state_d = ST_DN_CMP; end
      end
      ST_DN_CMP: begin
        ca = rd_q; cb = piv_q;
        if (!cr.lt) begin
          dn_d = dn_q - 1'b1;
          if (dn_q == lo_q || dn_q == '0) begin
            dn_d = dn_q - 1'b1; state_d = ST_UP_RD;
            if (dn_q == '0) dn_d = '1;
            state_d = ST_PUSH;
            if (up_q <= dn_q - 1'b1 && dn_q != '0) state_d = ST_SWAP;
          end else ra = AW'(dn_q - 1'b1);
        end else begin
          piv_d = piv_q;
          if (up_q <= dn_q) begin
            we = 1'b1; wa = up_q[AW-1:0]; wd = rd_q; state_d = ST_SWAP;
          end else state_d = ST_PUSH;
        end
      end
      ST_SWAP: begin
        we = 1'b1; wa = dn_q[AW-1:0]; wd = x_q;
        up_d = up_q + 1'b1; dn_d = (dn_q == '0) ? '1 : dn_q - 1'b1;
        state_d = ST_UP_RD;
      end
      ST_PUSH: begin
        if (!ph_q) begin
          if (up_q <= hi_q) begin
            swe = 1'b1; swa = sp_q[AW-1:0];
            swd = {up_q[AW-1:0], hi_q[AW-1:0]}; sp_d = sp_q + 1'b1;
          end
          ph_d = 1'b1;
        end else begin
          if (!dn_q[CW] && dn_q >= lo_q) begin
            swe = 1'b1; swa = sp_q[AW-1:0];
            swd = {lo_q[AW-1:0], dn_q[AW-1:0]}; sp_d = sp_q + 1'b1;
          end
          ph_d = 1'b0; state_d = ST_POP;
        end
      end
      ST_OUT_RD: begin
        ra = a_q[AW-1:0]; state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        ra = a_q[AW-1:0]; state_d = ST_OUT;
      end
      ST_OUT: begin
        ra = a_q[AW-1:0];
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          out_d.sorted_value = rd_q;
          out_d.final_res = (a_q + 1'b1 == (CW+1)'(cnt_q));
          out_d.truncated = ovf_q;
          if (a_q + 1'b1 == (CW+1)'(cnt_q)) begin
            cnt_d = '0; ovf_d = 1'b0; sp_d = '0; state_d = ST_LOAD;
          end else begin
            a_d = a_q + 1'b1; state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  `HQIS_ASSERT_IMPL(a_cnt_cap, clk_i, rst_ni, 1'b1, cnt_q <= CapC)
  `HQIS_ASSERT_NEXT(a_out_keep, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `HQIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `HQIS_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.last, !in_ready_o)
endmodule
`default_nettype wire
